/* src/pco_pkg.sv */
// Package for the Paillier ciphertext operations unit.
// Holds payload structs, operation and error codes, and default widths.
package pco_pkg;

   localparam int CIPHER_BITS_DEF = 64;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_SCALAR = 2'd1;
   localparam logic [1:0] FUNC_OBFUSCATE = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_RANGE = 2'd1;
   localparam logic [1:0] ERR_NO_INVERSE = 2'd2;

   localparam logic [1:0] CSR_MODULUS_N = 2'd0;
   localparam logic [1:0] CSR_MODULUS_N_SQUARED = 2'd1;
   localparam logic [1:0] CSR_MAX_POSITIVE = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] cipher_in;
      logic [63:0] operand;
   } req_type;

   typedef struct packed {
      logic [63:0] cipher_out;
      logic [1:0]  error_code;
   } rsp_type;

   // Command to the shared modular unit.
   typedef struct packed {
      logic start;
      logic op_div;   // 1: plain division a / b, 0: modular multiply a*b mod m
   } mu_cmd_type;

endpackage

/* src/pco_modunit.sv */
// Shared bit-serial arithmetic unit: modular multiply or integer division.
// Depends on pco_pkg. One bit per cycle.
module pco_modunit import pco_pkg::*; #(
   parameter int W = CIPHER_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  mu_cmd_type       cmd,
   input  logic [W-1:0]     a,
   input  logic [W-1:0]     b,
   input  logic [W-1:0]     m,
   output logic             done,
   output logic [W-1:0]     result,
   output logic [W-1:0]     remainder
);
   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          div_ff, div_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  m_ff, m_in;
   logic          done_ff, done_in;

   logic [W:0]    dbl;
   logic [W:0]    dbl_red;
   logic [W:0]    addv;
   logic [W-1:0]  mul_next;
   logic [W:0]    rem_sh;
   logic [W:0]    rem_sub;

   always_comb begin
      // Multiply step: acc = 2*acc mod m, then + a if bit set.
      dbl = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      addv = dbl_red + {1'b0, a_ff};
      if (b_ff[W-1]) begin
         mul_next = (addv >= {1'b0, m_ff}) ? W'(addv - {1'b0, m_ff}) : addv[W-1:0];
      end else begin
         mul_next = dbl_red[W-1:0];
      end
      // Division step: restoring, quotient shifts into a_ff.
      rem_sh = {acc_ff, a_ff[W-1]};
      rem_sub = rem_sh - {1'b0, b_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      m_in = m_ff;
      done_in = 1'b0;
      if (!busy_ff && cmd.start) begin
         busy_in = 1'b1;
         div_in = cmd.op_div;
         cnt_in = CW'(W);
         acc_in = '0;
         a_in = a;
         b_in = b;
         m_in = m;
      end else if (busy_ff) begin
         if (div_ff) begin
            if (!rem_sub[W]) begin
               acc_in = rem_sub[W-1:0];
               a_in = {a_ff[W-2:0], 1'b1};
            end else begin
               acc_in = rem_sh[W-1:0];
               a_in = {a_ff[W-2:0], 1'b0};
            end
         end else begin
            acc_in = mul_next;
            b_in = {b_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      div_ff <= div_in;
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
      m_ff <= m_in;
   end

   assign done = done_ff;
   assign result = div_ff ? a_ff : acc_ff;
   assign remainder = acc_ff;
endmodule

/* src/paillier_ciphertext_ops_unit.sv */
// Top level of the Paillier ciphertext operations unit.
// Depends on pco_pkg and pco_modunit (shared bit-serial modular multiply/divide).
//
// Usage: write modulus_n (index 0), modulus_n_squared (index 1) and
// max_positive (index 2) through the csr_ channel while the unit is idle.
// A command is taken at a clock edge with start high and busy low; req_data
// carries the operation, the ciphertext and the operand. busy stays high
// through the cycle of the result transfer, which shows on rsp_data for
// exactly one cycle with rsp_valid high. The receiver cannot stall the unit.
// All multiplies and divisions go through one bit-serial unit (W =
// CIPHER_BITS). Add takes three unit operations (two reductions and one
// multiply). Exponentiation takes up to two unit operations per exponent
// bit, and the exponent (k, n-k or n) fits in 32 bits. The inverse for
// negative scalars adds two unit operations per extended Euclid step, up
// to about 1.44*W steps. One command runs at a time.
// Reset is synchronous, clears the CSR registers and the result strobe and
// returns the sequencer to idle. With zero modulus or the unused operation
// code the result is zero with no error.
module paillier_ciphertext_ops_unit import pco_pkg::*; #(
   parameter int CIPHER_BITS = CIPHER_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [63:0]               csr_wdata
);
   localparam int W = CIPHER_BITS;
   localparam int EW = 64;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_RED_C   = 4'd1;
   localparam logic [3:0] ST_RED_D   = 4'd2;
   localparam logic [3:0] ST_DISPATCH = 4'd3;
   localparam logic [3:0] ST_EXP_MUL = 4'd4;
   localparam logic [3:0] ST_EXP_SQR = 4'd5;
   localparam logic [3:0] ST_INV_DIV = 4'd6;
   localparam logic [3:0] ST_INV_MUL = 4'd7;
   localparam logic [3:0] ST_FINAL   = 4'd8;
   localparam logic [3:0] ST_DONE    = 4'd9;
   localparam logic [3:0] ST_WAIT    = 4'd10;

   logic [31:0]  mod_n_ff;
   logic [63:0]  mod_n2_ff;
   logic [31:0]  max_pos_ff;

   logic [3:0]   state_ff, state_in;
   logic [3:0]   ret_ff, ret_in;      // marks which unit op is in flight
   logic [1:0]   func_ff, func_in;
   logic [W-1:0] c_ff, c_in;
   logic [W-1:0] d_ff, d_in;
   logic [63:0]  k_ff, k_in;
   logic [EW-1:0] e_ff, e_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] base_ff, base_in;
   logic [W-1:0] r0_ff, r0_in, r1_ff, r1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [1:0]   err_ff, err_in;
   logic         obf_ff, obf_in;      // obfuscate: final multiply by c
   logic         rv_ff, rv_in;
   logic [63:0]  out_ff, out_in;
   logic [1:0]   eout_ff, eout_in;

   mu_cmd_type   cmd;
   logic [W-1:0] mu_a, mu_b;
   logic         mu_done;
   logic [W-1:0] mu_res, mu_rem;
   logic [W-1:0] m_w;
   logic [W-1:0] one_m;
   logic [W-1:0] sub_t;
   logic         neg_k;
   logic [32:0]  ksum;

   assign m_w = mod_n2_ff[W-1:0];
   assign one_m = (m_w == W'(1)) ? '0 : W'(1);
   assign ksum = {1'b0, k_ff[31:0]} + {1'b0, max_pos_ff};
   assign neg_k = ksum >= {1'b0, mod_n_ff};
   // t0 - (q*t1 mod m) mod m, with mu_res the product.
   assign sub_t = (t0_ff >= mu_res) ? t0_ff - mu_res : t0_ff + (m_w - mu_res);

   pco_modunit #(.W(W)) u_mu (
      .clock(clock), .reset(reset), .cmd(cmd), .a(mu_a), .b(mu_b), .m(m_w),
      .done(mu_done), .result(mu_res), .remainder(mu_rem)
   );

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_n_ff <= '0;
         mod_n2_ff <= '0;
         max_pos_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODULUS_N: mod_n_ff <= csr_wdata[31:0];
            CSR_MODULUS_N_SQUARED: mod_n2_ff <= csr_wdata;
            CSR_MAX_POSITIVE: max_pos_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; func_in = func_ff;
      c_in = c_ff; d_in = d_ff; k_in = k_ff; e_in = e_ff;
      acc_in = acc_ff; base_in = base_ff; r0_in = r0_ff; r1_in = r1_ff;
      t0_in = t0_ff; t1_in = t1_ff; err_in = err_ff;
      obf_in = obf_ff; rv_in = 1'b0; out_in = out_ff; eout_in = eout_ff;
      cmd = '0; mu_a = '0; mu_b = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in = req_data.func;
               c_in = req_data.cipher_in[W-1:0];
               d_in = req_data.operand[W-1:0];
               k_in = req_data.operand;
               err_in = ERR_NONE;
               acc_in = '0;
               if (m_w == '0 || req_data.func == FUNC_UNUSED) begin
                  state_in = ST_DONE;
               end else begin
                  // c mod m as a division remainder
                  cmd.start = 1'b1; cmd.op_div = 1'b1;
                  mu_a = req_data.cipher_in[W-1:0]; mu_b = m_w;
                  state_in = ST_RED_C;
               end
            end
         end
         ST_RED_C: if (mu_done) begin
            c_in = mu_rem;
            cmd.start = 1'b1; cmd.op_div = 1'b1; mu_a = d_ff; mu_b = m_w;
            state_in = ST_RED_D;
         end
         ST_RED_D: if (mu_done) begin
            d_in = mu_rem;
            state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            obf_in = 1'b0;
            acc_in = one_m;
            case (func_ff)
               FUNC_ADD: begin
                  cmd.start = 1'b1; mu_a = c_ff; mu_b = d_ff;
                  state_in = ST_FINAL;
               end
               FUNC_OBFUSCATE: begin
                  obf_in = 1'b1; base_in = d_ff; e_in = EW'(mod_n_ff);
                  state_in = ST_EXP_MUL;
               end
               default: begin
                  if (k_ff >= {32'd0, mod_n_ff}) begin
                     err_in = ERR_RANGE; state_in = ST_DONE;
                  end else if (neg_k) begin
                     r0_in = m_w; r1_in = c_ff; t0_in = '0; t1_in = one_m;
                     e_in = EW'(mod_n_ff - k_ff[31:0]);
                     state_in = ST_INV_DIV;
                  end else begin
                     base_in = c_ff; e_in = k_ff; state_in = ST_EXP_MUL;
                  end
               end
            endcase
         end
         // Square-and-multiply: ret_ff marks which op is in flight.
         ST_EXP_MUL: begin
            if (ret_ff == ST_EXP_MUL && mu_done) begin
               acc_in = mu_res; ret_in = ST_IDLE;
               cmd.start = 1'b1; mu_a = base_ff; mu_b = base_ff;
               state_in = ST_EXP_SQR;
            end else if (ret_ff != ST_EXP_MUL) begin
               if (e_ff == '0) begin
                  if (obf_ff) begin
                     cmd.start = 1'b1; mu_a = c_ff; mu_b = acc_ff;
                     state_in = ST_FINAL;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else if (e_ff[0]) begin
                  cmd.start = 1'b1; mu_a = acc_ff; mu_b = base_ff;
                  ret_in = ST_EXP_MUL;
               end else begin
                  cmd.start = 1'b1; mu_a = base_ff; mu_b = base_ff;
                  state_in = ST_EXP_SQR;
               end
            end
         end
         ST_EXP_SQR: if (mu_done) begin
            base_in = mu_res; e_in = e_ff >> 1; state_in = ST_EXP_MUL;
         end
         ST_INV_DIV: begin
            if (ret_ff == ST_INV_DIV) begin
               if (mu_done) begin
                  // The multiplier reduces as it goes, so q*t1 mod m needs
                  // no separate reduction of the quotient.
                  cmd.start = 1'b1; mu_a = t1_ff; mu_b = mu_res;
                  r0_in = r1_ff; r1_in = mu_rem;
                  ret_in = ST_IDLE;
                  state_in = ST_INV_MUL;
               end
            end else if (r1_ff == '0) begin
               if (r0_ff != W'(1)) begin
                  err_in = ERR_NO_INVERSE; state_in = ST_DONE;
               end else begin
                  base_in = t0_ff; state_in = ST_EXP_MUL;
               end
            end else begin
               cmd.start = 1'b1; cmd.op_div = 1'b1; mu_a = r0_ff; mu_b = r1_ff;
               ret_in = ST_INV_DIV;
            end
         end
         ST_INV_MUL: if (mu_done) begin
            t0_in = t1_ff; t1_in = sub_t; state_in = ST_INV_DIV;
         end
         ST_FINAL: if (mu_done) begin
            acc_in = mu_res; state_in = ST_DONE;
         end
         ST_DONE: begin
            rv_in = 1'b1;
            out_in = (err_ff == ERR_NONE && m_w != '0 && func_ff != FUNC_UNUSED)
                     ? 64'(acc_ff) : 64'd0;
            eout_in = err_ff;
            state_in = ST_WAIT;
         end
         ST_WAIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         rv_ff <= rv_in;
      end
      func_ff <= func_in; c_ff <= c_in; d_ff <= d_in; k_ff <= k_in;
      e_ff <= e_in; acc_ff <= acc_in; base_ff <= base_in;
      r0_ff <= r0_in; r1_ff <= r1_in; t0_ff <= t0_in; t1_ff <= t1_in;
      err_ff <= err_in; obf_ff <= obf_in;
      out_ff <= out_in; eout_ff <= eout_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data.cipher_out = out_ff;
   assign rsp_data.error_code = eout_ff;

   // A result transfer is followed by return to idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> state_ff == ST_IDLE)
      else $error("sequencer not idle after result");
   // Results never come back to back.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("repeated result strobe");
   // Accepting a command makes the unit busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command accepted without going busy");
endmodule
